// ----- rtl/spl_pkg.sv -----
// Shared types and constants for the LCD pixel command stream block.
// No dependencies; imported by the capture, sequencer and top-level files.
package spl_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DIM_W     = 10;
    localparam int COORD_W   = 16;
    localparam int STEP_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 10'd16;

    localparam logic [15:0] IDX_WIN_X_START = 16'h0050;
    localparam logic [15:0] IDX_WIN_X_END   = 16'h0051;
    localparam logic [15:0] IDX_WIN_Y_START = 16'h0052;
    localparam logic [15:0] IDX_WIN_Y_END   = 16'h0053;
    localparam logic [15:0] IDX_GRAM_X      = 16'h0020;
    localparam logic [15:0] IDX_GRAM_Y      = 16'h0021;
    localparam logic [15:0] IDX_GRAM_WRITE  = 16'h0022;

    localparam logic [STEP_W-1:0] LAST_STEP = 4'd13;

    localparam logic RS_INDEX = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic        register_select;
        logic [15:0] bus_word;
        logic        last_word;
    } t_word;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [15:0]        colour;
    } t_pix_job;

endpackage

// ----- rtl/spl_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload types come from spl_pkg at instantiation.
interface spl_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/spl_pixel_capture.sv -----
// Configuration registers, image position counters and pixel input register.
// Depends on spl_pkg and spl_stream_if.
module spl_pixel_capture #(
    parameter int MAX_IMAGE_DIM = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [spl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spl_pkg::CFG_W-1:0]      i_cfg_data,
    spl_stream_if.sink                     i_pix,
    output spl_pkg::t_pix_job              o_job,
    output logic                           o_job_valid,
    input  logic                           i_job_take
);
    import spl_pkg::*;

    localparam int CW = $clog2(MAX_IMAGE_DIM);
    localparam int DW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam logic [DW-1:0] MAX_DIM = DW'(MAX_IMAGE_DIM);

    logic [COORD_W-1:0] r_origin_x;
    logic [COORD_W-1:0] r_origin_y;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [CW-1:0]      r_col, n_col;
    logic [CW-1:0]      r_row, n_row;
    logic               r_valid;
    t_pix_job           r_job, n_job;

    logic [DW-1:0] eff_w, eff_h, w_ext, h_ext, col_inc, row_inc;
    logic          accept;
    t_pixel        pix;

    assign pix    = i_pix.data;
    assign accept = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !r_valid || i_job_take;

    assign w_ext = DW'(r_width);
    assign h_ext = DW'(r_height);

    always_comb begin
        eff_w = (w_ext == '0) ? DW'(1) : ((w_ext > MAX_DIM) ? MAX_DIM : w_ext);
        eff_h = (h_ext == '0) ? DW'(1) : ((h_ext > MAX_DIM) ? MAX_DIM : h_ext);
        col_inc = DW'(r_col) + DW'(1);
        row_inc = DW'(r_row) + DW'(1);
        n_col = r_col;
        n_row = r_row;
        if (row_inc >= eff_h) begin
            n_row = '0;
            n_col = (col_inc >= eff_w) ? '0 : col_inc[CW-1:0];
        end else begin
            n_row = row_inc[CW-1:0];
        end
        n_job.x      = r_origin_x + COORD_W'(r_col);
        n_job.y      = r_origin_y + COORD_W'(r_row);
        n_job.colour = {pix.red[7:3], pix.green[7:2], pix.blue[7:3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_width    <= DIM_RESET;
            r_height   <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ORIGIN_X:     r_origin_x <= i_cfg_data;
                REG_ORIGIN_Y:     r_origin_y <= i_cfg_data;
                REG_IMAGE_WIDTH:  r_width    <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_height   <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else if (accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            // drop transparent pixels here
            r_valid <= (pix.alpha != 8'd0);
        end else if (i_job_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

    assign o_job       = r_job;
    assign o_job_valid = r_valid;
endmodule

// ----- rtl/spl_word_sequencer.sv -----
// Emits the fourteen LCD bus words of one visible pixel, one per transaction.
// Depends on spl_pkg and spl_stream_if.
module spl_word_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spl_pkg::t_pix_job i_job,
    input  logic              i_job_valid,
    output logic              o_job_take,
    spl_stream_if.source      o_word
);
    import spl_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    t_pix_job          r_job;
    t_word             word;
    logic              out_accept;
    logic              last;

    assign last       = (r_step == LAST_STEP);
    assign out_accept = o_word.valid && o_word.ready;
    assign o_job_take = i_job_valid && (!r_busy || (o_word.ready && last));

    always_comb begin
        word.register_select = r_step[0] ? RS_DATA : RS_INDEX;
        word.last_word       = last;
        case (r_step)
            4'd0:    word.bus_word = IDX_WIN_X_START;
            4'd1:    word.bus_word = r_job.x;
            4'd2:    word.bus_word = IDX_WIN_X_END;
            4'd3:    word.bus_word = r_job.x + 16'd1;
            4'd4:    word.bus_word = IDX_WIN_Y_START;
            4'd5:    word.bus_word = r_job.y;
            4'd6:    word.bus_word = IDX_WIN_Y_END;
            4'd7:    word.bus_word = r_job.y + 16'd1;
            4'd8:    word.bus_word = IDX_GRAM_X;
            4'd9:    word.bus_word = r_job.x;
            4'd10:   word.bus_word = IDX_GRAM_Y;
            4'd11:   word.bus_word = r_job.y;
            4'd12:   word.bus_word = IDX_GRAM_WRITE;
            4'd13:   word.bus_word = r_job.colour;
            default: word.bus_word = '0;
        endcase
    end

    assign o_word.valid = r_busy;
    assign o_word.data  = word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (o_job_take) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (out_accept) begin
            r_step <= r_step + 4'd1;
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
        end
    end
endmodule

// ----- rtl/sprite_pixel_lcd_command_stream_core.sv -----
// Top level of the LCD pixel command stream block.
// A visible pixel's transaction reaches its first word transaction through the
// capture register and then the sequencer job register.
// Throughput: fourteen words per visible pixel, one word per cycle from the
// word sequencer while o_word.ready holds; a transparent pixel emits nothing.
// Reset (synchronous, active low) clears counters, origins, sizes to 16.
module sprite_pixel_lcd_command_stream_core #(
    parameter int MAX_IMAGE_DIM = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [spl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spl_pkg::CFG_W-1:0]     i_cfg_data,
    spl_stream_if.sink                    i_pix,
    spl_stream_if.source                  o_word
);
    import spl_pkg::*;

    t_pix_job job;
    logic     job_valid;
    logic     job_take;

    spl_pixel_capture #(
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
    ) u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_take  (job_take)
    );

    spl_word_sequencer u_sequencer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_take  (job_take),
        .o_word      (o_word)
    );
endmodule
